### design/ptrs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PTRS symbol and subcarrier mapper.
// Used by ptrs_ctrl, ptrs_datapath and the top level; depends on nothing.
package ptrs_pkg;

    localparam int MASK_W     = 14;   // width of the symbol masks
    localparam int SYM_W      = 4;    // width of a symbol index inside the slot
    localparam int POS_W      = 5;    // symbol position plus time density headroom
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RB_SC      = 12;   // subcarriers per resource block

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_DENSITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_DENSITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RE_OFFSET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RNTI         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_RB       = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [1:0]  time_density_code;
        logic [2:0]  freq_density;
        logic [3:0]  re_offset;
        logic [15:0] rnti;
        logic [8:0]  num_rb;
    } t_cfg;

    typedef struct packed {
        logic load;      // capture a new allocation
        logic step;      // advance the symbol scan by one step
        logic publish;   // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic done;      // scan finished, result ready to publish
    } t_dp_status;

endpackage

### design/ptrs_ctrl.sv
`timescale 1ns / 1ps
// Controller of the PTRS mapper: sequences load, scan and result hand-off.
// Depends on ptrs_pkg for the state type and the command/status structs.
module ptrs_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output ptrs_pkg::t_dp_cmd      o_cmd,
    input  ptrs_pkg::t_dp_status   i_status
);
    import ptrs_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        w_out_free    = !r_out_valid || !i_out_stall;
        n_state       = r_state;
        o_cmd         = '0;
        o_in_stall    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!i_status.done) begin
                    o_cmd.step = 1'b1;
                end else if (w_out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // wait for the previous result to drain
                if (w_out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.publish || (r_out_valid && i_out_stall);
    end

    assign o_out_valid = r_out_valid;

endmodule

### design/ptrs_datapath.sv
`timescale 1ns / 1ps
// Datapath of the PTRS mapper: symbol scan registers, RB offset logic and
// the output register. Depends on ptrs_pkg; driven by ptrs_ctrl commands.
module ptrs_datapath #(
    parameter int SLOT_SYMBOLS = 14
) (
    input  logic                          i_clk,
    input  ptrs_pkg::t_dp_cmd             i_cmd,
    output ptrs_pkg::t_dp_status          o_status,
    input  ptrs_pkg::t_cfg                i_cfg,
    input  logic [ptrs_pkg::SYM_W-1:0]    i_start_symbol,
    input  logic [ptrs_pkg::SYM_W-1:0]    i_num_symbols,
    input  logic [ptrs_pkg::MASK_W-1:0]   i_dmrs_symbol_mask,
    output logic [ptrs_pkg::MASK_W-1:0]   o_ptrs_symbol_mask,
    output logic [1:0]                    o_rb_offset,
    output logic [5:0]                    o_first_subcarrier
);
    import ptrs_pkg::*;

    localparam int DMRS_EXT_W = 1 << SYM_W;
    localparam logic [MASK_W-1:0] SLOT_MASK = MASK_W'((1 << SLOT_SYMBOLS) - 1);
    localparam logic [POS_W-1:0]  LAST_SYM  = POS_W'(SLOT_SYMBOLS - 1);

    // scan state: current symbol, next PTRS candidate, last allocated symbol
    logic [POS_W-1:0]  r_l, n_l;
    logic [POS_W-1:0]  r_p, n_p;
    logic [POS_W-1:0]  r_last, n_last;
    logic              r_empty, n_empty;
    logic [MASK_W-1:0] r_dmrs, n_dmrs;
    logic [MASK_W-1:0] r_mask, n_mask;

    logic [MASK_W-1:0] r_ptrs_out;
    logic [1:0]        r_rbo_out;
    logic [5:0]        r_fsc_out;

    logic [POS_W-1:0]      w_lpt;
    logic [POS_W-1:0]      w_end_sum;
    logic [POS_W-1:0]      w_l_inc;
    logic [POS_W-1:0]      w_lref;
    logic [DMRS_EXT_W-1:0] w_dmrs_ext;
    logic                  w_dm_here;
    logic                  w_dm_next;
    logic [1:0]            w_rem;
    logic [1:0]            w_rbo;
    logic [5:0]            w_fsc;

    // rnti mod 3: base-4 digits sum to the same residue
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s5;
        logic [2:0] s3;
        logic [1:0] res;
        s5 = '0;
        for (int k = 0; k < 8; k++) begin
            s5 = s5 + 5'(v[2*k +: 2]);
        end
        s3 = 3'(s5[1:0]) + 3'(s5[3:2]) + 3'(s5[4]);
        case (s3) inside
            3'd0, 3'd3, 3'd6: res = 2'd0;
            3'd1, 3'd4, 3'd7: res = 2'd1;
            default:          res = 2'd2;
        endcase
        return res;
    endfunction

    always_comb begin
        w_lpt      = POS_W'(1) << i_cfg.time_density_code;
        w_end_sum  = POS_W'(i_start_symbol) + POS_W'(i_num_symbols) - POS_W'(1);
        w_l_inc    = r_l + POS_W'(1);
        // symbols beyond the slot read as no DM-RS
        w_dmrs_ext = DMRS_EXT_W'(r_dmrs);
        w_dm_here  = w_dmrs_ext[r_l[SYM_W-1:0]];
        w_dm_next  = w_dmrs_ext[w_l_inc[SYM_W-1:0]];
        w_lref     = w_dm_next ? w_l_inc : r_l;

        n_l     = r_l;
        n_p     = r_p;
        n_last  = r_last;
        n_empty = r_empty;
        n_dmrs  = r_dmrs;
        n_mask  = r_mask;
        if (i_cmd.load) begin
            n_l     = POS_W'(i_start_symbol);
            n_p     = POS_W'(i_start_symbol);
            n_last  = (w_end_sum > LAST_SYM) ? LAST_SYM : w_end_sum;
            n_empty = (i_num_symbols == '0) || (32'(i_start_symbol) >= SLOT_SYMBOLS);
            n_dmrs  = i_dmrs_symbol_mask & SLOT_MASK;
            n_mask  = '0;
        end else if (i_cmd.step) begin
            if (w_dm_here) begin
                // restart the reference at the DM-RS (second of a pair)
                n_p = w_lref + w_lpt;
                n_l = w_lref + POS_W'(1);
            end else if (r_l == r_p) begin
                n_mask = r_mask | (MASK_W'(1) << r_p[SYM_W-1:0]);
                n_p    = r_p + w_lpt;
                n_l    = w_l_inc;
            end else begin
                n_l = w_l_inc;
            end
        end

        // RB offset: Kpt is 2 or 4, remainder of num_rb taken by mask
        if (i_cfg.freq_density[2]) begin
            w_rem = i_cfg.num_rb[1:0];
        end else begin
            w_rem = {1'b0, i_cfg.num_rb[0]};
        end
        case (w_rem)
            2'd0:    w_rbo = i_cfg.freq_density[2] ? i_cfg.rnti[1:0] : {1'b0, i_cfg.rnti[0]};
            2'd1:    w_rbo = 2'd0;
            2'd2:    w_rbo = {1'b0, i_cfg.rnti[0]};
            default: w_rbo = mod3_16(i_cfg.rnti);
        endcase
        w_fsc = 6'(i_cfg.re_offset) + 6'(w_rbo) * 6'(RB_SC);
    end

    always_ff @(posedge i_clk) begin
        r_l     <= n_l;
        r_p     <= n_p;
        r_last  <= n_last;
        r_empty <= n_empty;
        r_dmrs  <= n_dmrs;
        r_mask  <= n_mask;
        if (i_cmd.publish) begin
            r_ptrs_out <= r_empty ? '0 : r_mask;
            r_rbo_out  <= w_rbo;
            r_fsc_out  <= w_fsc;
        end
    end

    assign o_status.done      = r_empty || (r_p > r_last);
    assign o_ptrs_symbol_mask = r_ptrs_out;
    assign o_rb_offset        = r_rbo_out;
    assign o_first_subcarrier = r_fsc_out;

endmodule

### design/ptrs_symbol_and_subcarrier_mapper.sv
`timescale 1ns / 1ps
// PTRS symbol and subcarrier mapper, top level: configuration registers,
// controller and datapath. Depends on ptrs_pkg, ptrs_ctrl, ptrs_datapath.
//
// One PDSCH allocation is taken per transaction and one result is returned.
// The symbol scan walks the allocation one symbol per clock: the item is
// accepted, one scan step is taken per visited symbol (a double DM-RS skips
// one), and the output register is loaded once the previous result has
// drained. The next allocation is taken as soon as the result sits in the
// output register, even while it is stalled. The RB offset and first
// subcarrier come from the configuration registers, which are written
// through a port that is always ready.
module ptrs_symbol_and_subcarrier_mapper #(
    parameter int SLOT_SYMBOLS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ptrs_pkg::SYM_W-1:0]        i_start_symbol,
    input  logic [ptrs_pkg::SYM_W-1:0]        i_num_symbols,
    input  logic [ptrs_pkg::MASK_W-1:0]       i_dmrs_symbol_mask,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ptrs_pkg::MASK_W-1:0]       o_ptrs_symbol_mask,
    output logic [1:0]                        o_rb_offset,
    output logic [5:0]                        o_first_subcarrier,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ptrs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ptrs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ptrs_pkg::*;

    t_cfg       r_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_density_code <= 2'd1;
            r_cfg.freq_density      <= 3'd2;
            r_cfg.re_offset         <= 4'd0;
            r_cfg.rnti              <= 16'd4096;
            r_cfg.num_rb            <= 9'd50;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TIME_DENSITY: r_cfg.time_density_code <= i_cfg_data[1:0];
                CFG_FREQ_DENSITY: r_cfg.freq_density      <= i_cfg_data[2:0];
                CFG_RE_OFFSET:    r_cfg.re_offset         <= i_cfg_data[3:0];
                CFG_RNTI:         r_cfg.rnti              <= i_cfg_data;
                CFG_NUM_RB:       r_cfg.num_rb            <= i_cfg_data[8:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    ptrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    ptrs_datapath #(
        .SLOT_SYMBOLS (SLOT_SYMBOLS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_cfg              (r_cfg),
        .i_start_symbol     (i_start_symbol),
        .i_num_symbols      (i_num_symbols),
        .i_dmrs_symbol_mask (i_dmrs_symbol_mask),
        .o_ptrs_symbol_mask (o_ptrs_symbol_mask),
        .o_rb_offset        (o_rb_offset),
        .o_first_subcarrier (o_first_subcarrier)
    );

    // an accepted allocation keeps the input side busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // no PTRS symbol outside the slot
    a_mask_in_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_ptrs_symbol_mask >> SLOT_SYMBOLS) == '0))
        else $error("PTRS mask has bits beyond the slot");

    // first subcarrier agrees with the offsets it was built from
    a_subcarrier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_first_subcarrier == 6'(r_cfg.re_offset) + 6'(o_rb_offset) * 6'(RB_SC)))
        else $error("first subcarrier inconsistent with RB offset");

endmodule
